@@ hdl/ols_pkg.sv @@
// Package for the ordered list store: operation and status codes, field widths
// and the payload types shared by the interfaces and the core.
// Depends on nothing.
`default_nettype none

package ols_pkg;

	// Field widths of the request and result payloads.
	localparam int OP_W      = 4;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int STS_W     = 3;
	localparam int CNT_OUT_W = 7;
	localparam int TOT_W     = 38;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [STS_W-1:0] status_t;

	// Operation codes.
	localparam op_t OP_INS_FRONT = 4'd0;
	localparam op_t OP_INS_BACK  = 4'd1;
	localparam op_t OP_INS_AT    = 4'd2;
	localparam op_t OP_RM_FRONT  = 4'd3;
	localparam op_t OP_RM_BACK   = 4'd4;
	localparam op_t OP_RM_AT     = 4'd5;
	localparam op_t OP_RM_FIRST  = 4'd6;
	localparam op_t OP_RM_ALL    = 4'd7;
	localparam op_t OP_READ      = 4'd8;
	localparam op_t OP_WRITE     = 4'd9;
	localparam op_t OP_STATS     = 4'd10;

	// Status codes.
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_FULL     = 3'd1;
	localparam status_t ST_EMPTY    = 3'd2;
	localparam status_t ST_BADPOS   = 3'd3;
	localparam status_t ST_NOTFOUND = 3'd4;

endpackage : ols_pkg

`default_nettype wire

@@ hdl/ols_req_if.sv @@
// Request channel of the ordered list store: valid/ready handshake with
// operation, position and value. Depends on ols_pkg.
`default_nettype none

interface ols_req_if;
	import ols_pkg::*;

	logic                    valid;
	logic                    ready;
	op_t                     operation;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);

endinterface : ols_req_if

`default_nettype wire

@@ hdl/ols_rsp_if.sv @@
// Result channel of the ordered list store: valid/ready handshake with status,
// data, entry count and statistics. Depends on ols_pkg.
`default_nettype none

interface ols_rsp_if;
	import ols_pkg::*;

	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic signed [VAL_W-1:0] data;
	logic [CNT_OUT_W-1:0]    entry_count;
	logic signed [VAL_W-1:0] maximum;
	logic signed [VAL_W-1:0] minimum;
	logic signed [TOT_W-1:0] total;

	modport source (output valid, output status, output data, output entry_count,
		output maximum, output minimum, output total, input ready);
	modport sink (input valid, input status, input data, input entry_count,
		input maximum, input minimum, input total, output ready);

endinterface : ols_rsp_if

`default_nettype wire

@@ hdl/ols_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module ols_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : ols_ram

`default_nettype wire

@@ hdl/ordered_list_store_core.sv @@
// Ordered list store core: a bounded list of signed 32-bit values held in one
// RAM and walked one entry per cycle. Depends on ols_pkg, ols_req_if,
// ols_rsp_if and ols_ram.
//
//   channel   direction   handshake      payload
//   req       in          valid/ready    operation, position, value
//   rsp       out         valid/ready    status, data, entry_count,
//                                        maximum, minimum, total
//
// A refused or unused request goes straight to S_DONE; a write or an insert at
// the back writes its slot in S_PUT. Reads, removals and stats walk up in S_UP;
// an insert that shifts entries walks down in S_DN, then writes in S_PUT.
// The walk issues one RAM read per cycle, and its writes trail the reads.
// Inserts walk from the back to the insert position, removals and stats walk
// from the start position (or the front) to the back.
// Reset clears the entry count; RAM contents are not cleared, since positions
// beyond the count are never read.
// The block is ready again at the edge that loads the result. A finished result
// waits in the output register; the next request is taken meanwhile, and its
// result is held back until the output register is free.
`default_nettype none

module ordered_list_store_core #(
	parameter int DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ols_req_if.sink   req,
	ols_rsp_if.source rsp
);
	import ols_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UP   = 3'd1;
	localparam logic [2:0] S_DN   = 3'd2;
	localparam logic [2:0] S_PUT  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]              state_q;
	logic [CW-1:0]           cnt_q;
	op_t                     op_q;
	logic [VAL_W-1:0]        val_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           rptr_q;
	logic [CW-1:0]           last_q;
	logic [CW-1:0]           wptr_q;
	logic [CW-1:0]           ri_q;
	logic [CW-1:0]           rmcnt_q;
	logic                    issue_q;
	logic                    rv_q;
	status_t                 status_q;
	logic [VAL_W-1:0]        dat_q;
	logic signed [VAL_W-1:0] mx_q;
	logic signed [VAL_W-1:0] mn_q;
	logic [TOT_W-1:0]        sum_q;

	// Output register.
	logic                    ovalid_q;
	status_t                 ost_q;
	logic [VAL_W-1:0]        odat_q;
	logic [CNT_OUT_W-1:0]    ocnt_q;
	logic [VAL_W-1:0]        omx_q;
	logic [VAL_W-1:0]        omn_q;
	logic [TOT_W-1:0]        otot_q;

	// Request decode.
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    cnt_x;
	logic [XW-1:0]    pos_m1;
	logic [CW-1:0]    pos_idx;
	logic [CW-1:0]    cnt_m1;
	logic [CW-1:0]    ins_idx;
	logic             full;
	logic             empty;
	logic             ins_bad;
	logic             acc_bad;
	logic [2:0]       d_state;
	status_t          d_status;
	logic [CW-1:0]    d_idx;
	logic [CW-1:0]    d_rptr;
	logic [CW-1:0]    d_last;
	logic [CW-1:0]    d_wptr;

	// Walk datapath.
	logic             is_rm;
	logic             is_match;
	logic             remove;
	logic             walk_end;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic             ram_re;
	logic [VAL_W-1:0] ram_rdata;

	ols_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rptr_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = ovalid_q;
	assign rsp.status      = ost_q;
	assign rsp.data        = odat_q;
	assign rsp.entry_count = ocnt_q;
	assign rsp.maximum     = omx_q;
	assign rsp.minimum     = omn_q;
	assign rsp.total       = otot_q;

	// Position checks against the current count.
	assign pos_x   = XW'(req.position);
	assign cnt_x   = XW'(cnt_q);
	assign pos_m1  = pos_x - XW'(1);
	assign pos_idx = pos_m1[CW-1:0];
	assign cnt_m1  = cnt_q - CW'(1);
	assign full    = (cnt_x == XW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign ins_bad = (pos_x == '0) || (pos_x > (cnt_x + XW'(1)));
	assign acc_bad = (pos_x == '0) || (pos_x > cnt_x);

	always_comb begin
		priority if (req.operation == OP_INS_FRONT) begin
			ins_idx = '0;
		end else if (req.operation == OP_INS_BACK) begin
			ins_idx = cnt_q;
		end else begin
			ins_idx = pos_idx;
		end
	end

	// Choose the first step, the walk range and the early status of a request.
	always_comb begin
		d_state  = S_DONE;
		d_status = ST_OK;
		d_idx    = '0;
		d_rptr   = '0;
		d_last   = cnt_m1;
		d_wptr   = '0;
		unique case (req.operation)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				d_idx  = ins_idx;
				d_rptr = cnt_m1;
				d_last = ins_idx;
				d_wptr = cnt_q;
				if (full) begin
					d_status = ST_FULL;
				end else if ((req.operation == OP_INS_AT) && ins_bad) begin
					d_status = ST_BADPOS;
				end else if (ins_idx == cnt_q) begin
					d_state = S_PUT;
				end else begin
					d_state = S_DN;
				end
			end
			OP_RM_FRONT, OP_RM_FIRST, OP_RM_ALL, OP_STATS: begin
				if (empty) begin
					d_status = ST_EMPTY;
				end else begin
					d_state = S_UP;
				end
			end
			OP_RM_BACK: begin
				d_idx  = cnt_m1;
				d_rptr = cnt_m1;
				d_wptr = cnt_m1;
				if (empty) begin
					d_status = ST_EMPTY;
				end else begin
					d_state = S_UP;
				end
			end
			OP_RM_AT: begin
				d_idx  = pos_idx;
				d_rptr = pos_idx;
				d_wptr = pos_idx;
				if (empty) begin
					d_status = ST_EMPTY;
				end else if (acc_bad) begin
					d_status = ST_BADPOS;
				end else begin
					d_state = S_UP;
				end
			end
			OP_READ: begin
				d_idx  = pos_idx;
				d_rptr = pos_idx;
				d_last = pos_idx;
				if (empty) begin
					d_status = ST_EMPTY;
				end else if (acc_bad) begin
					d_status = ST_BADPOS;
				end else begin
					d_state = S_UP;
				end
			end
			OP_WRITE: begin
				d_idx = pos_idx;
				if (empty) begin
					d_status = ST_EMPTY;
				end else if (acc_bad) begin
					d_status = ST_BADPOS;
				end else begin
					d_state = S_PUT;
				end
			end
			default: begin
			end
		endcase
	end

	// Classify the held operation and decide whether the returned entry is dropped.
	assign is_match = (op_q == OP_RM_FIRST) || (op_q == OP_RM_ALL);
	assign is_rm    = (op_q == OP_RM_FRONT) || (op_q == OP_RM_BACK) ||
		(op_q == OP_RM_AT) || is_match;

	always_comb begin
		priority if (op_q == OP_RM_ALL) begin
			remove = (ram_rdata == val_q);
		end else if (op_q == OP_RM_FIRST) begin
			remove = (rmcnt_q == '0) && (ram_rdata == val_q);
		end else begin
			remove = (ri_q == idx_q);
		end
	end

	assign walk_end = !issue_q && !rv_q;

	// RAM control: reads stream during a walk, and each write lands in the cycle after its read.
	assign ram_re = ((state_q == S_UP) || (state_q == S_DN)) && issue_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wptr_q[IW-1:0];
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_DN: begin
				ram_we = rv_q;
			end
			S_UP: begin
				ram_we = rv_q && is_rm && !remove;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[IW-1:0];
				ram_wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, walk counters, accumulators and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			issue_q  <= 1'b0;
			rv_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			rv_q <= ram_re;
			if (ram_re) begin
				ri_q <= rptr_q;
			end
			// The result state reloads the output register itself.
			if (ovalid_q && rsp.ready && (state_q != S_DONE)) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.operation;
						val_q    <= req.value;
						idx_q    <= d_idx;
						rptr_q   <= d_rptr;
						last_q   <= d_last;
						wptr_q   <= d_wptr;
						status_q <= d_status;
						rmcnt_q  <= '0;
						dat_q    <= '0;
						mx_q     <= '0;
						mn_q     <= '0;
						sum_q    <= '0;
						issue_q  <= 1'b1;
						state_q  <= d_state;
					end
				end
				S_DN: begin
					// Shift entries one place toward the back, from the back down.
					if (issue_q) begin
						rptr_q <= rptr_q - CW'(1);
						if (rptr_q == last_q) begin
							issue_q <= 1'b0;
						end
					end
					if (rv_q) begin
						wptr_q <= wptr_q - CW'(1);
					end
					if (walk_end) begin
						state_q <= S_PUT;
					end
				end
				S_UP: begin
					// Walk toward the back: compact, read or accumulate.
					if (issue_q) begin
						rptr_q <= rptr_q + CW'(1);
						if (rptr_q == last_q) begin
							issue_q <= 1'b0;
						end
					end
					if (rv_q) begin
						if (is_rm) begin
							if (remove) begin
								rmcnt_q <= rmcnt_q + CW'(1);
								if (rmcnt_q == '0) begin
									dat_q <= ram_rdata;
								end
							end else begin
								wptr_q <= wptr_q + CW'(1);
							end
						end else if (op_q == OP_READ) begin
							dat_q <= ram_rdata;
						end else begin
							sum_q <= sum_q + TOT_W'($signed(ram_rdata));
							if ((ri_q == '0) || ($signed(ram_rdata) > mx_q)) begin
								mx_q <= $signed(ram_rdata);
							end
							if ((ri_q == '0) || ($signed(ram_rdata) < mn_q)) begin
								mn_q <= $signed(ram_rdata);
							end
						end
					end
					if (walk_end) begin
						if (is_rm) begin
							cnt_q <= cnt_q - rmcnt_q;
						end
						if (is_match && (rmcnt_q == '0)) begin
							status_q <= ST_NOTFOUND;
						end
						if (op_q == OP_RM_ALL) begin
							dat_q <= VAL_W'(rmcnt_q);
						end
						state_q <= S_DONE;
					end
				end
				S_PUT: begin
					if (op_q != OP_WRITE) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hand the result over once the output register is free.
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						ost_q    <= status_q;
						odat_q   <= dat_q;
						ocnt_q   <= cnt_x[CNT_OUT_W-1:0];
						omx_q    <= mx_q;
						omn_q    <= mn_q;
						otot_q   <= sum_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The count never exceeds the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// Compaction never writes ahead of the entry just read.
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP && ram_we) |-> (wptr_q <= ri_q))
		else $error("compaction write ahead of read");

	// A removal walk never drops more entries than are held.
	a_rm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP) |-> (rmcnt_q <= cnt_q))
		else $error("removed more entries than held");

	// Leaving the result state always presents a result.
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!ovalid_q || rsp.ready)) |=>
		(ovalid_q && state_q == S_IDLE))
		else $error("result not presented on completion");

endmodule : ordered_list_store_core

`default_nettype wire

@@ verif/ordered_list_store_core_test.sv @@
// Self-checking testbench for ordered_list_store_core: a scoreboard class predicts every
// result from its own copy of the list, and plain tasks drive the request and result channels.
// Depends on ols_pkg, ols_req_if, ols_rsp_if and the core itself.
`default_nettype none

module ordered_list_store_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ols_pkg::*;

	localparam int DEPTH        = 64;
	localparam int RANDOM_ITEMS = 1700;
	localparam int STEADY_TAIL  = 200;
	localparam int CYCLE_LIMIT  = 1_000_000;

	// Operation codes the core leaves unused; requests with them change nothing.
	localparam op_t OP_UNUSED_LO = 4'd11;
	localparam op_t OP_UNUSED_HI = 4'd15;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] data;
		logic [CNT_OUT_W-1:0]    entry_count;
		logic signed [VAL_W-1:0] maximum;
		logic signed [VAL_W-1:0] minimum;
		logic signed [TOT_W-1:0] total;
	} list_result_t;

	// Scoreboard: keeps its own copy of the list and a queue of the results still owed.
	class ordered_list_board;
		logic signed [VAL_W-1:0] entries [DEPTH];
		int count;
		list_result_t awaited [$];
		int errors;
		int checked;
		int peak;
		int full_refusals;
		int empty_refusals;

		task report(string what);
			errors++;
			if (errors <= 50) begin
				$display("[%0t] mismatch on result %0d: %s", $time, checked, what);
			end
		endtask

		// Shift the tail back by one and place v at index idx.
		function void open_slot(int idx, logic signed [VAL_W-1:0] v);
			for (int i = count; i > idx; i--) begin
				entries[i] = entries[i - 1];
			end
			entries[idx] = v;
			count++;
			if (count > peak) begin
				peak = count;
			end
		endfunction

		// Close the gap at index idx and hand back the value that was there.
		function logic signed [VAL_W-1:0] take_slot(int idx);
			logic signed [VAL_W-1:0] v;
			v = entries[idx];
			for (int i = idx; i + 1 < count; i++) begin
				entries[i] = entries[i + 1];
			end
			count--;
			return v;
		endfunction

		// Apply one accepted request to the list copy and queue the result it must give.
		function void note_request(op_t op, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
			list_result_t r;
			int p;
			int k;
			int hit;
			logic signed [VAL_W-1:0] hi;
			logic signed [VAL_W-1:0] lo;
			logic signed [TOT_W-1:0] sum;
			r = '{default: '0};
			r.status = ST_OK;
			p = pos;
			if (op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_AT) begin
				// A full list refuses before the position is looked at.
				if (count >= DEPTH) begin
					r.status = ST_FULL;
				end else if (op == OP_INS_FRONT) begin
					open_slot(0, val);
				end else if (op == OP_INS_BACK) begin
					open_slot(count, val);
				end else if (p < 1 || p > count + 1) begin
					r.status = ST_BADPOS;
				end else begin
					open_slot(p - 1, val);
				end
			end else if (op <= OP_STATS) begin
				if (count == 0) begin
					r.status = ST_EMPTY;
				end else if (op == OP_RM_FRONT) begin
					r.data = take_slot(0);
				end else if (op == OP_RM_BACK) begin
					r.data = take_slot(count - 1);
				end else if (op == OP_RM_AT || op == OP_READ || op == OP_WRITE) begin
					if (p < 1 || p > count) begin
						r.status = ST_BADPOS;
					end else if (op == OP_RM_AT) begin
						r.data = take_slot(p - 1);
					end else if (op == OP_READ) begin
						r.data = entries[p - 1];
					end else begin
						entries[p - 1] = val;
					end
				end else if (op == OP_RM_FIRST) begin
					hit = -1;
					for (int i = 0; i < count && hit < 0; i++) begin
						if (entries[i] == val) begin
							hit = i;
						end
					end
					if (hit < 0) begin
						r.status = ST_NOTFOUND;
					end else begin
						r.data = take_slot(hit);
					end
				end else if (op == OP_RM_ALL) begin
					// Compact the survivors toward the front; data is the number dropped.
					k = 0;
					for (int i = 0; i < count; i++) begin
						if (entries[i] != val) begin
							entries[k] = entries[i];
							k++;
						end
					end
					r.data = VAL_W'(count - k);
					count = k;
					if (r.data == 0) begin
						r.status = ST_NOTFOUND;
					end
				end else begin
					hi = entries[0];
					lo = entries[0];
					sum = '0;
					for (int i = 0; i < count; i++) begin
						if (entries[i] > hi) begin
							hi = entries[i];
						end
						if (entries[i] < lo) begin
							lo = entries[i];
						end
						sum = sum + {{(TOT_W - VAL_W){entries[i][VAL_W-1]}}, entries[i]};
					end
					r.maximum = hi;
					r.minimum = lo;
					r.total = sum;
				end
			end
			if (r.status == ST_FULL) begin
				full_refusals++;
			end
			if (r.status == ST_EMPTY) begin
				empty_refusals++;
			end
			r.entry_count = count[CNT_OUT_W-1:0];
			awaited.push_back(r);
		endfunction

		// Compare one accepted result, field by field, with the oldest one owed.
		task check_result(list_result_t got);
			list_result_t want;
			if (awaited.size() == 0) begin
				report("result arrived with no request outstanding");
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.status !== want.status) begin
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			end
			if (got.data !== want.data) begin
				report($sformatf("data %0d, expected %0d", got.data, want.data));
			end
			if (got.entry_count !== want.entry_count) begin
				report($sformatf("entry_count %0d, expected %0d", got.entry_count,
					want.entry_count));
			end
			if (got.maximum !== want.maximum) begin
				report($sformatf("maximum %0d, expected %0d", got.maximum, want.maximum));
			end
			if (got.minimum !== want.minimum) begin
				report($sformatf("minimum %0d, expected %0d", got.minimum, want.minimum));
			end
			if (got.total !== want.total) begin
				report($sformatf("total %0d, expected %0d", got.total, want.total));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	ols_req_if req_ch ();
	ols_rsp_if rsp_ch ();

	ordered_list_store_core #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	ordered_list_board book;
	int idle_pct;
	bit steady;
	int sent;
	int cycles;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Run exceeded %0d cycles with %0d results outstanding.", CYCLE_LIMIT,
					book.awaited.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Present one request, with an optional idle burst first, and hold it until accepted.
	task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 15);
		end
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.position  <= pos;
		req_ch.value     <= val;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		book.note_request(op, pos, val);
		sent++;
	endtask

	// Result side: check every accepted result and stall in random bursts.
	initial begin
		int stall_left;
		list_result_t got;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status      = rsp_ch.status;
				got.data        = rsp_ch.data;
				got.entry_count = rsp_ch.entry_count;
				got.maximum     = rsp_ch.maximum;
				got.minimum     = rsp_ch.minimum;
				got.total       = rsp_ch.total;
				book.check_result(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 15) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Main sequence: reset, directed requests, then random segments of varying character.
	initial begin
		int useful;
		int mode;
		int seg_len;
		int ins_w;
		int rm_w;
		int pick;
		int cnt;
		int lim;
		op_t op;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;

		book = new();
		idle_pct = 30;
		steady = 1'b0;
		sent = 0;
		arst_n <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_INS_FRONT;
		req_ch.position  <= '0;
		req_ch.value     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty refusals, bad positions at both ends, extreme values,
		// unused codes, misses and hits of the match removals.
		send_request(OP_STATS, 7'd0, 32'sd0);
		send_request(OP_RM_FRONT, 7'd0, 32'sd0);
		send_request(OP_RM_ALL, 7'd0, 32'sd0);
		send_request(OP_WRITE, 7'd1, 32'sd9);
		send_request(OP_INS_AT, 7'd0, 32'sd1);
		send_request(OP_INS_AT, 7'd2, 32'sd1);
		send_request(OP_INS_AT, 7'd1, VAL_MAX);
		send_request(OP_INS_BACK, 7'd0, VAL_MIN);
		send_request(OP_INS_FRONT, 7'd0, -32'sd1);
		send_request(OP_INS_AT, 7'd4, 32'sd0);
		send_request(OP_INS_AT, 7'd2, 32'sd0);
		send_request(OP_READ, 7'd0, 32'sd0);
		send_request(OP_READ, 7'd127, 32'sd0);
		send_request(OP_READ, 7'd5, 32'sd0);
		send_request(OP_WRITE, 7'd6, 32'sd3);
		send_request(OP_WRITE, 7'd1, 32'sd5);
		send_request(OP_STATS, 7'd0, 32'sd0);
		send_request(OP_UNUSED_LO, 7'd1, 32'sd5);
		send_request(OP_UNUSED_HI, 7'd127, VAL_MIN);
		send_request(OP_RM_FIRST, 7'd0, 32'sd7);
		send_request(OP_RM_ALL, 7'd0, 32'sd7);
		send_request(OP_RM_ALL, 7'd0, 32'sd0);
		send_request(OP_RM_AT, 7'd4, 32'sd0);
		send_request(OP_RM_AT, 7'd2, 32'sd0);
		send_request(OP_RM_FIRST, 7'd0, VAL_MIN);
		send_request(OP_RM_BACK, 7'd0, 32'sd0);

		// Random: segments that fill the list, drain it, or churn around a level.
		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			seg_len = $urandom_range(20, 120);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 50;
			endcase
			case (mode)
				0: begin
					ins_w = 60;
					rm_w = 10;
				end
				1: begin
					ins_w = 15;
					rm_w = 55;
				end
				default: begin
					ins_w = 35;
					rm_w = 35;
				end
			endcase
			for (int j = 0; j < seg_len && useful < RANDOM_ITEMS; j++) begin
				if (useful >= RANDOM_ITEMS - STEADY_TAIL) begin
					steady = 1'b1;
				end
				cnt = book.count;

				pick = $urandom_range(0, 99);
				if (pick < ins_w) begin
					op = op_t'($urandom_range(OP_INS_FRONT, OP_INS_AT));
				end else if (pick < ins_w + rm_w) begin
					op = op_t'($urandom_range(OP_RM_FRONT, OP_RM_ALL));
				end else if (pick < 98) begin
					op = op_t'($urandom_range(OP_READ, OP_STATS));
				end else begin
					op = op_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				end

				// Mostly legal positions, with zero, just past the end and anything at all.
				lim = (op <= OP_INS_AT) ? cnt + 1 : ((cnt == 0) ? 1 : cnt);
				case ($urandom_range(0, 9))
					0: pos = '0;
					1: pos = POS_W'($urandom_range(0, 127));
					2: pos = POS_W'(lim + 1);
					default: pos = POS_W'($urandom_range(1, lim));
				endcase

				// Values that match held entries, a small pool for duplicates, extremes.
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						if (cnt > 0) begin
							val = book.entries[$urandom_range(0, cnt - 1)];
						end else begin
							val = $urandom;
						end
					end
					4, 5, 6: val = $urandom_range(0, 7) - 4;
					7: begin
						case ($urandom_range(0, 3))
							0: val = VAL_MAX;
							1: val = VAL_MIN;
							2: val = '0;
							default: val = '1;
						endcase
					end
					default: val = $urandom;
				endcase

				send_request(op, pos, val);
				if (op <= OP_STATS) begin
					useful++;
				end
			end
		end
		req_ch.valid <= 1'b0;

		// Drain: wait for every owed result, then allow for a full walk to be safe.
		while (book.awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (DEPTH + 10) @(posedge clk);

		$display("Covered %0d requests and %0d results; the list peaked at %0d of %0d entries.",
			sent, book.checked, book.peak, DEPTH);
		$display("Refusals seen: %0d on a full list, %0d on an empty one; %0d mismatches.",
			book.full_refusals, book.empty_refusals, book.errors);
		if (book.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule : ordered_list_store_core_test

`default_nettype wire

@@ filelist.f @@
hdl/ols_pkg.sv
hdl/ols_req_if.sv
hdl/ols_rsp_if.sv
hdl/ols_ram.sv
hdl/ordered_list_store_core.sv
verif/ordered_list_store_core_test.sv
